// ===== rtl/dhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared widths and constants of the density heat-map colormap.
// ----------------------------------------------------------------------------
package dhc_pkg;

   localparam int DENSITY_FRAC_BITS = 8;
   localparam int DENSITY_W         = 24;
   localparam int LEVEL_W           = 8;

   localparam logic [DENSITY_W-1:0] DENSITY_MAX_RESET =
      DENSITY_W'(1 << DENSITY_FRAC_BITS);

   // Q0.16 segment bounds at 0.33 and 0.66
   localparam logic [16:0] SEG_A = 17'd21627;
   localparam logic [16:0] SEG_B = 17'd43254;
   localparam logic [16:0] Q_ONE = 17'd65536;

   localparam logic [14:0] SEG_W_A = 15'd21627;
   localparam logic [14:0] SEG_W_C = 15'd22282;

   localparam logic [17:0] RECIP_A = 18'((64'd1 << 32) / 64'(SEG_W_A));
   localparam logic [17:0] RECIP_C = 18'((64'd1 << 32) / 64'(SEG_W_C));

   localparam logic [1:0] SEG_LOW  = 2'd0;
   localparam logic [1:0] SEG_MID  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;

   typedef logic [1:0] seg_type;

endpackage

// ===== rtl/dhc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_req_if
// Density transaction channel: valid, ready and one cell density.
// ----------------------------------------------------------------------------
interface dhc_req_if import dhc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DENSITY_W-1:0] cell_density;

   modport source (output valid, output cell_density, input ready);
   modport sink   (input valid, input cell_density, output ready);
endinterface

// ===== rtl/dhc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_rsp_if
// Color transaction channel: valid, ready and three channel levels.
// ----------------------------------------------------------------------------
interface dhc_rsp_if import dhc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

// ===== rtl/density_heatmap_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// density_heatmap_color
// Maps a Q16.8 cell density to an RGB heat-map color.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one cell density per transaction, rsp_chan returns the
//   red, green and blue levels of that cell, in order, one per transaction.
//   csr_wr_en / csr_wr_data load the Q16.8 normalizing maximum; write it only
//   while no transaction is in flight.
//   From request acceptance to response valid the pipeline has one
//   capture stage, 16 restoring divide stages (one quotient bit each), 17
//   square-root stages (one root bit each), four stages for the segment
//   position (reciprocal multiply and correction), two smoothstep multiply
//   stages, a channel gain stage and the output register.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   Reset empties the pipeline and sets the maximum to 1.0.
//   When the receiver stalls, the whole pipeline holds and req_chan.ready
//   drops until the output register is taken.
// ----------------------------------------------------------------------------
module density_heatmap_color import dhc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dhc_req_if.sink              req_chan,
   dhc_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [DENSITY_W-1:0] csr_wr_data
);

   localparam int DIV_STEPS = 16;
   localparam int SQ_STEPS  = 17;
   localparam int ST_SQ0    = DIV_STEPS + 1;
   localparam int ST_SEG    = ST_SQ0 + SQ_STEPS;
   localparam int ST_MP     = ST_SEG + 1;
   localparam int ST_MQ     = ST_MP + 1;
   localparam int ST_U      = ST_MQ + 1;
   localparam int ST_UU     = ST_U + 1;
   localparam int ST_S      = ST_UU + 1;
   localparam int ST_CH     = ST_S + 1;
   localparam int ST_OUT    = ST_CH + 1;

   logic [DENSITY_W-1:0] density_max_ff;
   logic                 vld_ff [0:ST_OUT];
   logic                 adv;

   assign adv            = !vld_ff[ST_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         density_max_ff <= DENSITY_MAX_RESET;
      end else if (csr_wr_en) begin
         density_max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ST_OUT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i <= ST_OUT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // divide: ratio = density * 2^16 / max, saturated to 1.0, and 0 when max is 0
   logic [DENSITY_W-1:0] dv_rem_ff  [0:DIV_STEPS];
   logic [15:0]          dv_q_ff    [0:DIV_STEPS];
   logic                 dv_sat_ff  [0:DIV_STEPS];
   logic                 dv_zero_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= req_chan.cell_density;
         dv_q_ff[0]    <= '0;
         dv_sat_ff[0]  <= req_chan.cell_density >= density_max_ff;
         dv_zero_ff[0] <= density_max_ff == '0;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [DENSITY_W:0]   rem2;
      logic                 take;
      logic [DENSITY_W-1:0] rem_in;

      always_comb begin
         rem2 = {dv_rem_ff[k-1], 1'b0};
         take = rem2 >= {1'b0, density_max_ff};
         rem_in = take ? DENSITY_W'(rem2 - {1'b0, density_max_ff}) : DENSITY_W'(rem2);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k]  <= rem_in;
            dv_q_ff[k]    <= {dv_q_ff[k-1][14:0], take};
            dv_sat_ff[k]  <= dv_sat_ff[k-1];
            dv_zero_ff[k] <= dv_zero_ff[k-1];
         end
      end
   end

   logic [16:0] ratio;

   always_comb begin
      if (dv_zero_ff[DIV_STEPS]) begin
         ratio = '0;
      end else if (dv_sat_ff[DIV_STEPS]) begin
         ratio = Q_ONE;
      end else begin
         ratio = {1'b0, dv_q_ff[DIV_STEPS]};
      end
   end

   // square root of ratio * 2^16, one root bit per stage
   logic [16:0] sq_ratio_ff [0:SQ_STEPS-1];
   logic [18:0] sq_rem_ff   [0:SQ_STEPS-1];
   logic [16:0] sq_root_ff  [0:SQ_STEPS-1];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [16:0] ratio_prev;
      logic [18:0] rem_prev;
      logic [16:0] root_prev;
      logic [33:0] xw;
      logic [20:0] cat;
      logic [20:0] trial;
      logic [18:0] rem_in;
      logic [16:0] root_in;

      if (k == 0) begin : g_first
         assign ratio_prev = ratio;
         assign rem_prev   = '0;
         assign root_prev  = '0;
      end else begin : g_next
         assign ratio_prev = sq_ratio_ff[k-1];
         assign rem_prev   = sq_rem_ff[k-1];
         assign root_prev  = sq_root_ff[k-1];
      end

      always_comb begin
         xw    = {1'b0, ratio_prev, 16'b0};
         cat   = {rem_prev, xw[2*(16-k)+1 -: 2]};
         trial = {2'b0, root_prev, 2'b01};
         if (cat >= trial) begin
            rem_in  = 19'(cat - trial);
            root_in = {root_prev[15:0], 1'b1};
         end else begin
            rem_in  = 19'(cat);
            root_in = {root_prev[15:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ratio_ff[k] <= ratio_prev;
            sq_rem_ff[k]   <= rem_in;
            sq_root_ff[k]  <= root_in;
         end
      end
   end

   // segment and offset
   logic [16:0] t_val;
   seg_type     seg_in;
   logic [14:0] d_in;
   seg_type     sg_seg_ff;
   logic [14:0] sg_d_ff;

   assign t_val = sq_root_ff[SQ_STEPS-1];

   always_comb begin
      if (t_val < SEG_A) begin
         seg_in = SEG_LOW;
         d_in   = 15'(t_val);
      end else if (t_val < SEG_B) begin
         seg_in = SEG_MID;
         d_in   = 15'(t_val - SEG_A);
      end else begin
         seg_in = SEG_HIGH;
         d_in   = 15'(t_val - SEG_B);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sg_seg_ff <= seg_in;
         sg_d_ff   <= d_in;
      end
   end

   // u = d * 2^16 / width by reciprocal and one correction
   seg_type     mp_seg_ff;
   logic [14:0] mp_d_ff;
   logic [32:0] mp_prod_ff;
   logic [17:0] recip;

   assign recip = (sg_seg_ff == SEG_HIGH) ? RECIP_C : RECIP_A;

   always_ff @(posedge clock) begin
      if (adv) begin
         mp_seg_ff  <= sg_seg_ff;
         mp_d_ff    <= sg_d_ff;
         mp_prod_ff <= 33'(sg_d_ff * recip);
      end
   end

   seg_type     mq_seg_ff;
   logic [14:0] mq_d_ff;
   logic [16:0] mq_qe_ff;
   logic [31:0] mq_qw_ff;
   logic [14:0] width_mp;

   assign width_mp = (mp_seg_ff == SEG_HIGH) ? SEG_W_C : SEG_W_A;

   always_ff @(posedge clock) begin
      if (adv) begin
         mq_seg_ff <= mp_seg_ff;
         mq_d_ff   <= mp_d_ff;
         mq_qe_ff  <= mp_prod_ff[32:16];
         mq_qw_ff  <= 32'(mp_prod_ff[32:16] * width_mp);
      end
   end

   seg_type     uv_seg_ff;
   logic [16:0] uv_u_ff;
   logic [31:0] u_rem;
   logic [14:0] width_mq;

   assign width_mq = (mq_seg_ff == SEG_HIGH) ? SEG_W_C : SEG_W_A;
   assign u_rem    = {1'b0, mq_d_ff, 16'b0} - mq_qw_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         uv_seg_ff <= mq_seg_ff;
         uv_u_ff   <= (u_rem >= {17'b0, width_mq}) ? mq_qe_ff + 17'd1 : mq_qe_ff;
      end
   end

   // smoothstep s = u*u*(3 - 2u)
   seg_type     uu_seg_ff;
   logic [16:0] uu_u_ff;
   logic [33:0] uu_sq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         uu_seg_ff <= uv_seg_ff;
         uu_u_ff   <= uv_u_ff;
         uu_sq_ff  <= 34'(uv_u_ff * uv_u_ff);
      end
   end

   seg_type     sm_seg_ff;
   logic [16:0] sm_s_ff;
   logic [17:0] cubic_k;
   logic [51:0] cubic_p;

   assign cubic_k = 18'(3 * 65536) - {uu_u_ff, 1'b0};
   assign cubic_p = 52'(uu_sq_ff * cubic_k);

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_seg_ff <= uu_seg_ff;
         sm_s_ff   <= cubic_p[48:32];
      end
   end

   // channel gains
   logic [7:0]  gain_r;
   logic [7:0]  gain_g;
   logic [7:0]  gain_b;
   logic [24:0] prod_r;
   logic [24:0] prod_g;
   logic [24:0] prod_b;
   logic [24:0] prod_b_up;
   seg_type     ch_seg_ff;
   logic [7:0]  ch_r_ff;
   logic [7:0]  ch_g_ff;
   logic [7:0]  ch_b_ff;

   always_comb begin
      case (sm_seg_ff)
         SEG_LOW: begin
            gain_r = 8'd20;
            gain_g = 8'd80;
            gain_b = 8'd100;
         end
         SEG_MID: begin
            gain_r = 8'd200;
            gain_g = 8'd130;
            gain_b = 8'd80;
         end
         default: begin
            gain_r = 8'd27;
            gain_g = 8'd33;
            gain_b = 8'd195;
         end
      endcase
      prod_r    = 25'(gain_r * sm_s_ff);
      prod_g    = 25'(gain_g * sm_s_ff);
      prod_b    = 25'(gain_b * sm_s_ff);
      prod_b_up = (sm_seg_ff == SEG_MID) ? prod_b + 25'd65535 : prod_b;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ch_seg_ff <= sm_seg_ff;
         ch_r_ff   <= prod_r[23:16];
         ch_g_ff   <= prod_g[23:16];
         ch_b_ff   <= prod_b_up[23:16];
      end
   end

   // bases and output register
   logic [7:0] out_r_in;
   logic [7:0] out_g_in;
   logic [7:0] out_b_in;
   logic [7:0] out_r_ff;
   logic [7:0] out_g_ff;
   logic [7:0] out_b_ff;

   always_comb begin
      case (ch_seg_ff)
         SEG_LOW: begin
            out_r_in = 8'd8 + ch_r_ff;
            out_g_in = 8'd12 + ch_g_ff;
            out_b_in = 8'd40 + ch_b_ff;
         end
         SEG_MID: begin
            out_r_in = 8'd28 + ch_r_ff;
            out_g_in = 8'd92 + ch_g_ff;
            out_b_in = 8'd140 - ch_b_ff;
         end
         default: begin
            out_r_in = 8'd228 + ch_r_ff;
            out_g_in = 8'd222 + ch_g_ff;
            out_b_in = 8'd60 + ch_b_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_r_ff <= out_r_in;
         out_g_ff <= out_g_in;
         out_b_ff <= out_b_in;
      end
   end

   assign rsp_chan.red_level   = out_r_ff;
   assign rsp_chan.green_level = out_g_ff;
   assign rsp_chan.blue_level  = out_b_ff;

   a_div_rem_below_max: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && !dv_sat_ff[DIV_STEPS] && !dv_zero_ff[DIV_STEPS]
      |-> dv_rem_ff[DIV_STEPS] < density_max_ff)
      else $error("divide remainder not below maximum");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SEG - 1] |-> t_val <= Q_ONE)
      else $error("square root above one");

   a_u_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_U] |-> uv_u_ff <= Q_ONE)
      else $error("segment position above one");

   a_s_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_S] |-> sm_s_ff <= Q_ONE)
      else $error("smoothstep above one");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted transaction lost at entry");

endmodule
